// ----- hdl/slu_pkg.sv -----
// Package for the SIRS lattice site update block.
// Holds grid geometry, cell state codes, register indexes and payload types.
// No dependencies.
`default_nettype none

package slu_pkg;

  localparam int GRID_SIDE  = 64;
  localparam int COORD_W    = $clog2(GRID_SIDE);
  localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int CELL_W     = 2;
  localparam int FRAC_W     = 16;
  localparam int THR_W      = 17;
  localparam int CFG_IDX_W  = 2;

  // Cell state codes.
  localparam logic [CELL_W-1:0] ST_SUSC    = 2'd0;
  localparam logic [CELL_W-1:0] ST_INF     = 2'd1;
  localparam logic [CELL_W-1:0] ST_REM     = 2'd2;
  localparam logic [CELL_W-1:0] ST_ILLEGAL = 2'd3;

  // Item kinds.
  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_WRITE  = 1'b1;

  // Neighbor directions.
  localparam logic [1:0] DIR_EAST  = 2'd0;
  localparam logic [1:0] DIR_WEST  = 2'd1;
  localparam logic [1:0] DIR_SOUTH = 2'd2;
  localparam logic [1:0] DIR_NORTH = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_INFECT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEATH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REBIRTH = 2'd2;

  typedef struct packed {
    logic                kind;
    logic [COORD_W-1:0]  site_x;
    logic [COORD_W-1:0]  site_y;
    logic [FRAC_W-1:0]   uniform_frac;
    logic [1:0]          direction;
    logic [CELL_W-1:0]   write_value;
  } in_item_t;

  typedef struct packed {
    logic [CELL_W-1:0] old_state;
    logic [CELL_W-1:0] new_state;
    logic              changed;
  } out_item_t;

  typedef struct packed {
    logic [THR_W-1:0] infect;
    logic [THR_W-1:0] death;
    logic [THR_W-1:0] rebirth;
  } thr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] data;
  } grid_wr_t;

  // Cell (x, y) lives at x + GRID_SIDE * y.
  function automatic logic [ADDR_W-1:0] site_addr(input logic [COORD_W-1:0] x,
                                                  input logic [COORD_W-1:0] y);
    site_addr = {y, x};
  endfunction

  function automatic logic [COORD_W-1:0] wrap_inc(input logic [COORD_W-1:0] v);
    wrap_inc = (v == COORD_W'(GRID_SIDE - 1)) ? '0 : v + COORD_W'(1);
  endfunction

  function automatic logic [COORD_W-1:0] wrap_dec(input logic [COORD_W-1:0] v);
    wrap_dec = (v == '0) ? COORD_W'(GRID_SIDE - 1) : v - COORD_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] nbr_addr(input logic [COORD_W-1:0] x,
                                                 input logic [COORD_W-1:0] y,
                                                 input logic [1:0]         dir);
    logic [COORD_W-1:0] nx;
    logic [COORD_W-1:0] ny;
    nx = x;
    ny = y;
    case (dir)
      DIR_EAST:  nx = wrap_inc(x);
      DIR_WEST:  nx = wrap_dec(x);
      DIR_SOUTH: ny = wrap_inc(y);
      default:   ny = wrap_dec(y);
    endcase
    nbr_addr = site_addr(nx, ny);
  endfunction

endpackage

`default_nettype wire

// ----- hdl/slu_if.sv -----
// Valid/ready channel interfaces for input items and result items.
// Depends on slu_pkg.
`default_nettype none

interface slu_in_if;
  import slu_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface slu_out_if;
  import slu_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- hdl/sirs_lattice_site_update_top.sv -----
// Top level of the SIRS lattice site update block: config registers, grid
// memory, one update stage and the result register.
// Depends on slu_pkg, slu_if, slu_grid_ram and slu_rule.
//
//   channel | dir | handshake           | payload
//   --------+-----+---------------------+--------------------------------------
//   in_i    | in  | valid/ready         | kind, site_x, site_y, uniform_frac,
//           |     |                     | direction, write_value
//   out_o   | out | valid/ready         | old_state, new_state, changed
//   cfg     | in  | cfg_we_i, no ready  | cfg_idx_i, cfg_data_i
//
// One item is accepted per cycle when unstalled; it passes s1, then out_q.
// The pace is set by the grid memory: two reads at acceptance, one write as
// the item leaves the update stage, with a bypass for a back-to-back hit.
// After reset the grid is cleared one cell per cycle, 4096 cells, with in_i
// ready held low; configuration writes are taken during that time.
// A stalled result holds the update stage, and the input stalls behind it.
`default_nettype none

module sirs_lattice_site_update_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  slu_in_if.sink                          in_i,
  slu_out_if.source                       out_o,
  input  logic                            cfg_we_i,
  input  logic [slu_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [slu_pkg::THR_W-1:0]       cfg_data_i
);
  import slu_pkg::*;

  thr_t              thr_q, thr_d;

  logic              s1_vld_q, s1_vld_d;
  in_item_t          s1_item_q;
  logic              s1_fwd_site_q;
  logic              s1_fwd_nbr_q;
  logic [CELL_W-1:0] s1_fwd_val_q;

  logic              out_vld_q, out_vld_d;
  out_item_t         out_q;

  logic              clr_busy;
  logic              in_fire;
  logic              s1_fire;
  logic [ADDR_W-1:0] in_site_addr;
  logic [ADDR_W-1:0] in_nbr_addr;
  logic [ADDR_W-1:0] s1_addr;
  logic [CELL_W-1:0] rd_site;
  logic [CELL_W-1:0] rd_nbr;
  logic [CELL_W-1:0] site_state;
  logic [CELL_W-1:0] nbr_state;
  out_item_t         s1_res;
  grid_wr_t          grid_wr;

  // Configuration registers.
  always_comb begin
    thr_d = thr_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_INFECT:  thr_d.infect  = cfg_data_i;
        CFG_DEATH:   thr_d.death   = cfg_data_i;
        CFG_REBIRTH: thr_d.rebirth = cfg_data_i;
        default:     thr_d = thr_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else begin
      thr_q <= thr_d;
    end
  end

  // Handshake and stage control.
  assign s1_fire    = s1_vld_q & (~out_vld_q | out_o.ready);
  assign in_i.ready = ~clr_busy & (~s1_vld_q | s1_fire);
  assign in_fire    = in_i.valid & in_i.ready;

  assign in_site_addr = site_addr(in_i.payload.site_x, in_i.payload.site_y);
  assign in_nbr_addr  = nbr_addr(in_i.payload.site_x, in_i.payload.site_y,
                                 in_i.payload.direction);
  assign s1_addr      = site_addr(s1_item_q.site_x, s1_item_q.site_y);

  assign grid_wr.en   = s1_fire;
  assign grid_wr.addr = s1_addr;
  assign grid_wr.data = s1_res.new_state;

  slu_grid_ram u_grid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (in_fire),
    .rd_addr_a_i (in_site_addr),
    .rd_addr_b_i (in_nbr_addr),
    .rd_data_a_o (rd_site),
    .rd_data_b_o (rd_nbr),
    .wr_i        (grid_wr),
    .busy_o      (clr_busy)
  );

  // The memory read returns the old cell when the item ahead writes the
  // same cell on the accepting edge, so that value is captured alongside.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q     <= in_i.payload;
      s1_fwd_site_q <= s1_fire & (in_site_addr == s1_addr);
      s1_fwd_nbr_q  <= s1_fire & (in_nbr_addr == s1_addr);
      s1_fwd_val_q  <= s1_res.new_state;
    end
  end

  assign site_state = s1_fwd_site_q ? s1_fwd_val_q : rd_site;
  assign nbr_state  = s1_fwd_nbr_q  ? s1_fwd_val_q : rd_nbr;

  slu_rule u_rule (
    .item_i       (s1_item_q),
    .site_state_i (site_state),
    .nbr_state_i  (nbr_state),
    .thr_i        (thr_q),
    .res_o        (s1_res)
  );

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (in_fire) begin
      s1_vld_d = 1'b1;
    end else if (s1_fire) begin
      s1_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (s1_fire) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_q <= s1_res;
    end
  end

  assign out_o.valid   = out_vld_q;
  assign out_o.payload = out_q;

endmodule

`default_nettype wire

// ----- hdl/slu_grid_ram.sv -----
// Cell grid storage: two registered read ports, one write port, and a
// clearing pass after reset. Depends on slu_pkg.
`default_nettype none

module slu_grid_ram (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [slu_pkg::ADDR_W-1:0]   rd_addr_a_i,
  input  logic [slu_pkg::ADDR_W-1:0]   rd_addr_b_i,
  output logic [slu_pkg::CELL_W-1:0]   rd_data_a_o,
  output logic [slu_pkg::CELL_W-1:0]   rd_data_b_o,
  input  slu_pkg::grid_wr_t            wr_i,
  output logic                         busy_o
);
  import slu_pkg::*;

  logic [CELL_W-1:0] mem [CELL_COUNT];
  logic [ADDR_W-1:0] clr_cnt_q, clr_cnt_d;
  logic              busy_q, busy_d;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [CELL_W-1:0] wdata;

  always_comb begin
    clr_cnt_d = clr_cnt_q;
    busy_d    = busy_q;
    if (busy_q) begin
      clr_cnt_d = clr_cnt_q + ADDR_W'(1);
      if (clr_cnt_q == ADDR_W'(CELL_COUNT - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      busy_q    <= 1'b1;
    end else begin
      clr_cnt_q <= clr_cnt_d;
      busy_q    <= busy_d;
    end
  end

  // The clearing pass owns the write port until it is done.
  assign we    = busy_q | wr_i.en;
  assign waddr = busy_q ? clr_cnt_q : wr_i.addr;
  assign wdata = busy_q ? ST_SUSC : wr_i.data;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en_i) begin
      rd_data_a_o <= mem[rd_addr_a_i];
      rd_data_b_o <= mem[rd_addr_b_i];
    end
  end

  assign busy_o = busy_q;

endmodule

`default_nettype wire

// ----- hdl/slu_rule.sv -----
// Transition rule for one site: write items and stochastic SIRS updates.
// Depends on slu_pkg.
`default_nettype none

module slu_rule (
  input  slu_pkg::in_item_t            item_i,
  input  logic [slu_pkg::CELL_W-1:0]   site_state_i,
  input  logic [slu_pkg::CELL_W-1:0]   nbr_state_i,
  input  slu_pkg::thr_t                thr_i,
  output slu_pkg::out_item_t           res_o
);
  import slu_pkg::*;

  logic [THR_W-1:0]  frac_ext;
  logic [CELL_W-1:0] nxt;

  assign frac_ext = {1'b0, item_i.uniform_frac};

  always_comb begin
    nxt = site_state_i;
    if (item_i.kind == KIND_WRITE) begin
      // A write of the unused code leaves the cell as it is.
      if (item_i.write_value != ST_ILLEGAL) begin
        nxt = item_i.write_value;
      end
    end else begin
      case (site_state_i)
        ST_SUSC: begin
          if (frac_ext < thr_i.infect && nbr_state_i == ST_INF) begin
            nxt = ST_INF;
          end
        end
        ST_INF: begin
          if (frac_ext < thr_i.death) begin
            nxt = ST_REM;
          end
        end
        ST_REM: begin
          if (frac_ext < thr_i.rebirth) begin
            nxt = ST_SUSC;
          end
        end
        default: nxt = site_state_i;
      endcase
    end
  end

  assign res_o.old_state = site_state_i;
  assign res_o.new_state = nxt;
  assign res_o.changed   = (nxt != site_state_i);

endmodule

`default_nettype wire

// ----- hdl/slu_checker.sv -----
// Port-level checks for the SIRS lattice site update block, bound to the top.
// Depends on slu_pkg.
`default_nettype none

module slu_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [slu_pkg::CELL_W-1:0]    old_state_i,
  input  logic [slu_pkg::CELL_W-1:0]    new_state_i,
  input  logic                          changed_i
);
  import slu_pkg::*;

  // The change flag must agree with the two states it reports on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (changed_i == (old_state_i != new_state_i)))
    else $error("changed flag disagrees with old and new state");

  // The grid never holds the unused code, so neither state may show it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (new_state_i != ST_ILLEGAL))
    else $error("new_state carries the unused code");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (old_state_i != ST_ILLEGAL))
    else $error("old_state carries the unused code");

  // A stalled result beat stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(old_state_i) && $stable(new_state_i)))
    else $error("stalled result beat changed");

endmodule

bind sirs_lattice_site_update_top slu_checker u_slu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .old_state_i (out_o.payload.old_state),
  .new_state_i (out_o.payload.new_state),
  .changed_i   (out_o.payload.changed)
);

`default_nettype wire

// ----- tb/sv/tb_sirs_lattice_site_update_top.sv -----
// Self-checking testbench for sirs_lattice_site_update_top: random and directed
// cell writes and update attempts checked against an in-bench lattice predictor.
// Depends on slu_pkg, slu_if and the RTL of the block.
`timescale 1ns / 100ps

module tb_sirs_lattice_site_update_top;
  import slu_pkg::*;

  localparam int WATCHDOG_LIMIT = 12000;
  localparam int LONG_HOLD      = 80;
  localparam int PHASE_ITEMS    = 75;
  localparam int PHASES         = 6;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [THR_W-1:0]     cfg_data;

  slu_in_if  in_ch ();
  slu_out_if out_ch ();

  sirs_lattice_site_update_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Predictor state: a copy of the lattice and the three thresholds.
  logic [CELL_W-1:0] lattice [CELL_COUNT];
  logic [THR_W-1:0]  thr_infect;
  logic [THR_W-1:0]  thr_death;
  logic [THR_W-1:0]  thr_rebirth;

  in_item_t  pending_items [$];
  out_item_t site_results [$];

  bit gaps_on;
  bit in_took;
  int send_gap;
  int hold_left;
  int holds_asked;
  int holds_served;
  int quiet_cycles;
  int mismatches;
  int items_done;
  int writes_done;
  int changes_seen;
  int results_seen;
  int settings_used;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = CFG_INFECT;
    cfg_data       = '0;
    in_ch.valid    = 1'b0;
    in_ch.payload  = '0;
    out_ch.ready   = 1'b0;
    thr_infect     = '0;
    thr_death      = '0;
    thr_rebirth    = '0;
    gaps_on        = 1'b1;
    in_took        = 1'b0;
    send_gap       = 0;
    hold_left      = 0;
    holds_asked    = 0;
    holds_served   = 0;
    quiet_cycles   = 0;
    mismatches     = 0;
    items_done     = 0;
    writes_done    = 0;
    changes_seen   = 0;
    results_seen   = 0;
    settings_used  = 0;
    for (int i = 0; i < CELL_COUNT; i++) lattice[i] = ST_SUSC;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns, result %0d: %s", $time, results_seen, msg);
    mismatches++;
  endtask

  // Applies one item to the predicted lattice and returns the expected result.
  function automatic out_item_t apply_site_update(input in_item_t it);
    int cx;
    int cy;
    int nx;
    int ny;
    logic [CELL_W-1:0] prior;
    logic [CELL_W-1:0] next_st;
    out_item_t res;
    cx = int'(it.site_x) % GRID_SIDE;
    cy = int'(it.site_y) % GRID_SIDE;
    nx = cx;
    ny = cy;
    prior = lattice[cx + GRID_SIDE * cy];
    next_st = prior;
    if (it.kind == KIND_WRITE) begin
      if (it.write_value != ST_ILLEGAL) next_st = it.write_value;
    end else begin
      case (prior)
        ST_SUSC: begin
          if ({1'b0, it.uniform_frac} < thr_infect) begin
            case (it.direction)
              DIR_EAST:  nx = (cx + 1) % GRID_SIDE;
              DIR_WEST:  nx = (cx + GRID_SIDE - 1) % GRID_SIDE;
              DIR_SOUTH: ny = (cy + 1) % GRID_SIDE;
              default:   ny = (cy + GRID_SIDE - 1) % GRID_SIDE;
            endcase
            if (lattice[nx + GRID_SIDE * ny] == ST_INF) next_st = ST_INF;
          end
        end
        ST_INF: begin
          if ({1'b0, it.uniform_frac} < thr_death) next_st = ST_REM;
        end
        ST_REM: begin
          if ({1'b0, it.uniform_frac} < thr_rebirth) next_st = ST_SUSC;
        end
        default: ;
      endcase
    end
    lattice[cx + GRID_SIDE * cy] = next_st;
    res.old_state = prior;
    res.new_state = next_st;
    res.changed   = (prior != next_st);
    return res;
  endfunction

  function automatic in_item_t make_item(input logic kind, input int x, input int y,
                                         input int frac, input logic [1:0] dir,
                                         input logic [CELL_W-1:0] wval);
    in_item_t it;
    it.kind         = kind;
    it.site_x       = COORD_W'(x);
    it.site_y       = COORD_W'(y);
    it.uniform_frac = FRAC_W'(frac);
    it.direction    = dir;
    it.write_value  = wval;
    return it;
  endfunction

  // Most sites come from a 4x4 window across the wrap corner, so that
  // neighbors interact; the rest are spread over the whole grid.
  function automatic in_item_t rand_site_item();
    in_item_t it;
    bit near_corner;
    near_corner = ($urandom_range(0, 3) != 0);
    it.kind = ($urandom_range(0, 3) == 0) ? KIND_WRITE : KIND_UPDATE;
    if (near_corner) begin
      it.site_x = COORD_W'(GRID_SIDE - 2 + $urandom_range(0, 3));
      it.site_y = COORD_W'(GRID_SIDE - 2 + $urandom_range(0, 3));
    end else begin
      it.site_x = COORD_W'($urandom_range(0, GRID_SIDE - 1));
      it.site_y = COORD_W'($urandom_range(0, GRID_SIDE - 1));
    end
    it.uniform_frac = FRAC_W'($urandom_range(0, 65535));
    it.direction    = 2'($urandom_range(0, 3));
    it.write_value  = CELL_W'($urandom_range(0, 3));
    return it;
  endfunction

  // Writes all three thresholds; called only while nothing is in flight.
  task automatic set_thresholds(input logic [THR_W-1:0] inf_t,
                                input logic [THR_W-1:0] dth_t,
                                input logic [THR_W-1:0] reb_t);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_INFECT;
    cfg_data <= inf_t;
    @(negedge clk_i);
    cfg_idx  <= CFG_DEATH;
    cfg_data <= dth_t;
    @(negedge clk_i);
    cfg_idx  <= CFG_REBIRTH;
    cfg_data <= reb_t;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    thr_infect  = inf_t;
    thr_death   = dth_t;
    thr_rebirth = reb_t;
    settings_used++;
  endtask

  // Checked at the rising edge, when a beat popped at the falling edge already
  // shows as valid.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_items.size() != 0 || in_ch.valid || site_results.size() != 0);
  endtask

  // Input driver: holds a beat until it is taken, with random gaps between beats.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_ch.valid || in_took)) begin
      if (send_gap != 0) begin
        send_gap    <= send_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_ch.payload <= pending_items.pop_front();
        in_ch.valid   <= 1'b1;
        if (gaps_on && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 10);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stall bursts, plus long hold-offs on request.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if (holds_served != holds_asked) begin
        holds_served <= holds_served + 1;
        hold_left    <= LONG_HOLD - 1;
        out_ch.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 6) == 0) begin
        hold_left    <= $urandom_range(0, 9);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor: results are checked before the same edge's input beat is predicted.
  always @(posedge clk_i) begin
    out_item_t want;
    out_item_t got;
    bit in_beat;
    bit out_beat;
    in_beat  = rst_ni && in_ch.valid && in_ch.ready;
    out_beat = rst_ni && out_ch.valid && out_ch.ready;
    in_took <= in_beat;
    if (out_beat) begin
      results_seen++;
      got = out_ch.payload;
      if (site_results.size() == 0) begin
        report_mismatch("result beat with no expectation waiting");
      end else begin
        want = site_results.pop_front();
        if (got.old_state !== want.old_state)
          report_mismatch($sformatf("old_state got %0d want %0d", got.old_state,
                                    want.old_state));
        if (got.new_state !== want.new_state)
          report_mismatch($sformatf("new_state got %0d want %0d", got.new_state,
                                    want.new_state));
        if (got.changed !== want.changed)
          report_mismatch($sformatf("changed got %0d want %0d", got.changed,
                                    want.changed));
      end
    end
    if (in_beat) begin
      want = apply_site_update(in_ch.payload);
      site_results.push_back(want);
      items_done++;
      if (in_ch.payload.kind == KIND_WRITE) writes_done++;
      if (want.changed) changes_seen++;
    end
    if (in_beat || out_beat) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [THR_W-1:0] settings [PHASES][3];
    settings = '{'{17'd32768, 17'd16384, 17'd8192},
                 '{17'd65536, 17'd65536, 17'd65536},
                 '{17'd0, 17'd0, 17'd0},
                 '{17'd131071, 17'd1, 17'd65535},
                 '{17'd0, 17'd0, 17'd0},
                 '{17'd40000, 17'd20000, 17'd30000}};
    for (int k = 0; k < 3; k++) settings[4][k] = THR_W'($urandom_range(0, 70000));

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Thresholds are taken while the grid is still being cleared.
    set_thresholds(17'd65536, 17'd0, 17'd1);
    @(posedge clk_i);
    pending_items.push_back(make_item(KIND_UPDATE, 0, 0, 0, DIR_EAST, ST_ILLEGAL));
    pending_items.push_back(make_item(KIND_WRITE, 63, 63, 65535, DIR_NORTH, ST_INF));
    // A write of the illegal code leaves the cell alone.
    pending_items.push_back(make_item(KIND_WRITE, 0, 0, 0, DIR_EAST, ST_ILLEGAL));
    // Each direction reaches the infected corner cell across a wrap or not.
    pending_items.push_back(make_item(KIND_UPDATE, 0, 63, 65535, DIR_WEST, ST_SUSC));
    pending_items.push_back(make_item(KIND_UPDATE, 63, 0, 65535, DIR_NORTH, ST_SUSC));
    pending_items.push_back(make_item(KIND_UPDATE, 62, 63, 65535, DIR_EAST, ST_SUSC));
    pending_items.push_back(make_item(KIND_UPDATE, 63, 62, 65535, DIR_SOUTH, ST_SUSC));
    pending_items.push_back(make_item(KIND_UPDATE, 63, 63, 0, DIR_EAST, ST_REM));
    pending_items.push_back(make_item(KIND_WRITE, 63, 63, 0, DIR_EAST, ST_REM));
    pending_items.push_back(make_item(KIND_UPDATE, 63, 63, 0, DIR_EAST, ST_INF));
    pending_items.push_back(make_item(KIND_WRITE, 5, 5, 0, DIR_EAST, ST_REM));
    pending_items.push_back(make_item(KIND_UPDATE, 5, 5, 1, DIR_EAST, ST_SUSC));
    // Back-to-back: the neighbor is written by the beat just before.
    pending_items.push_back(make_item(KIND_WRITE, 10, 10, 0, DIR_EAST, ST_INF));
    pending_items.push_back(make_item(KIND_UPDATE, 11, 10, 0, DIR_WEST, ST_SUSC));
    pending_items.push_back(make_item(KIND_UPDATE, 11, 10, 0, DIR_EAST, ST_SUSC));
    pending_items.push_back(make_item(KIND_WRITE, 0, 0, 0, DIR_EAST, ST_SUSC));
    pending_items.push_back(make_item(KIND_WRITE, 0, 0, 0, DIR_EAST, ST_INF));
    pending_items.push_back(make_item(KIND_UPDATE, 0, 1, 65535, DIR_NORTH, ST_SUSC));
    pending_items.push_back(make_item(KIND_UPDATE, 1, 0, 65535, DIR_WEST, ST_SUSC));
    pending_items.push_back(make_item(KIND_UPDATE, 0, 0, 65535, DIR_SOUTH, ST_SUSC));
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) gaps_on = 1'b0;
      set_thresholds(settings[p][0], settings[p][1], settings[p][2]);
      @(posedge clk_i);
      for (int n = 0; n < PHASE_ITEMS; n++) pending_items.push_back(rand_site_item());
      // Hold results back long enough for the block to fill and stall its input.
      if (p == 0 || p == 3) holds_asked++;
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    if (site_results.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived",
                                site_results.size()));
    $display("Covered %0d items (%0d writes, %0d state changes) under %0d threshold sets,",
             items_done, writes_done, changes_seen, settings_used);
    $display("with %0d results checked and %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/slu_pkg.sv
hdl/slu_if.sv
hdl/slu_grid_ram.sv
hdl/slu_rule.sv
hdl/sirs_lattice_site_update_top.sv
hdl/slu_checker.sv
tb/sv/tb_sirs_lattice_site_update_top.sv
